[src/assert_macros.svh]
// Assertion macros used by the sorted multiset table core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define SMT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Check that cons holds in the cycle after ante.
`define SMT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/smt_pkg.sv]
// Types and constants of the sorted multiset table.
package smt_pkg;

    localparam int CAPACITY_DEF    = 16;
    localparam int VALUE_WIDTH_DEF = 32;

    localparam int CMD_WIDTH    = 2;
    localparam int STATUS_WIDTH = 2;
    localparam int COUNT_FIELD  = 5;
    localparam int TOTAL_FIELD  = 32;
    localparam int IN_VALUE_W   = 32;
    localparam int S_TDATA_W    = 32;
    localparam int S_TUSER_W    = 2;
    localparam int M_TDATA_W    = 48;
    localparam int M_TUSER_W    = 3;

    typedef enum logic [CMD_WIDTH-1:0] {
        CMD_INSERT = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_LOOKUP = 2'd2,
        CMD_CLEAR  = 2'd3
    } cmd_e_t;

    typedef enum logic [STATUS_WIDTH-1:0] {
        STATUS_DONE      = 2'd0,
        STATUS_FULL      = 2'd1,
        STATUS_NOT_FOUND = 2'd2
    } status_e_t;

    typedef enum logic {
        ST_IDLE   = 1'b0,
        ST_UPDATE = 1'b1
    } state_e_t;

    typedef enum logic [1:0] {
        OP_HOLD   = 2'd0,
        OP_INSERT = 2'd1,
        OP_REMOVE = 2'd2
    } cell_op_e_t;

    typedef struct packed {
        logic       cmp_en;
        cell_op_e_t op;
    } cell_ctl_t;

endpackage

[src/smt_cell.sv]
// One cell of the sorted row: holds an entry, compares it and shifts with its neighbors.
module smt_cell #(
    parameter int VALUE_WIDTH = smt_pkg::VALUE_WIDTH_DEF
) (
    input  logic                   aclk,
    input  smt_pkg::cell_ctl_t     ctl,
    input  logic                   occupied,
    input  logic [VALUE_WIDTH-1:0] cmp_key,
    input  logic [VALUE_WIDTH-1:0] ins_key,
    input  logic [VALUE_WIDTH-1:0] left_entry,
    input  logic                   left_le,
    input  logic [VALUE_WIDTH-1:0] right_entry,
    output logic [VALUE_WIDTH-1:0] entry,
    output logic                   le,
    output logic                   eq
);
    import smt_pkg::*;

    logic [VALUE_WIDTH-1:0] entry_reg;
    logic [VALUE_WIDTH-1:0] entry_next;
    logic                   ge_reg;
    logic                   eq_reg;

    assign le    = ge_reg || !occupied;
    assign entry = entry_reg;
    assign eq    = eq_reg;

    always_comb begin
        entry_next = entry_reg;
        unique case (ctl.op)
            OP_HOLD: begin
                entry_next = entry_reg;
            end
            OP_INSERT: begin
                if (left_le) begin
                    entry_next = left_entry;
                end else if (le) begin
                    entry_next = ins_key;
                end
            end
            OP_REMOVE: begin
                if (ge_reg) begin
                    entry_next = right_entry;
                end
            end
            default: begin
                entry_next = entry_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
        if (ctl.cmp_en) begin
            ge_reg <= occupied && ($signed(entry_reg) >= $signed(cmp_key));
            eq_reg <= occupied && (entry_reg == cmp_key);
        end
    end

endmodule

[src/smt_row.sv]
// Row of sorted cells chained left to right, with the hit reduction.
module smt_row #(
    parameter int CAPACITY    = smt_pkg::CAPACITY_DEF,
    parameter int VALUE_WIDTH = smt_pkg::VALUE_WIDTH_DEF
) (
    input  logic                           aclk,
    input  smt_pkg::cell_ctl_t             ctl,
    input  logic [$clog2(CAPACITY+1)-1:0]  count,
    input  logic [VALUE_WIDTH-1:0]         cmp_key,
    input  logic [VALUE_WIDTH-1:0]         ins_key,
    output logic                           found
);
    import smt_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);

    logic [VALUE_WIDTH-1:0] entry_vec [CAPACITY];
    logic [CAPACITY-1:0]    le_vec;
    logic [CAPACITY-1:0]    eq_vec;

    assign found = |eq_vec;

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic [VALUE_WIDTH-1:0] left_entry;
        logic                   left_le;
        logic [VALUE_WIDTH-1:0] right_entry;
        logic                   occupied;

        assign occupied = count > CW'(i);

        if (i == 0) begin : g_first
            assign left_entry = entry_vec[i];
            assign left_le    = 1'b0;
        end else begin : g_inner
            assign left_entry = entry_vec[i-1];
            assign left_le    = le_vec[i-1];
        end

        if (i == CAPACITY - 1) begin : g_last
            assign right_entry = entry_vec[i];
        end else begin : g_body
            assign right_entry = entry_vec[i+1];
        end

        smt_cell #(
            .VALUE_WIDTH (VALUE_WIDTH)
        ) u_cell (
            .aclk        (aclk),
            .ctl         (ctl),
            .occupied    (occupied),
            .cmp_key     (cmp_key),
            .ins_key     (ins_key),
            .left_entry  (left_entry),
            .left_le     (left_le),
            .right_entry (right_entry),
            .entry       (entry_vec[i]),
            .le          (le_vec[i]),
            .eq          (eq_vec[i])
        );
    end

endmodule

[src/sorted_multiset_table_core.sv]
// Top level of the sorted multiset table: command control, counters and result register.
//
//  channel | direction | tdata                          | tuser
//  s_      | in        | value                          | cmd
//  m_      | out       | entry_count, even_entries, total | status, found
//
// In the accept cycle every cell registers its compare; in the update state the row
// shifts and the result register loads.
// Clear, insert, remove and look up all go through these same steps.
// aresetn empties the table at once; no clearing pass is run.
// A result held by m_tready low stalls the update cycle and keeps s_tready low.
`include "assert_macros.svh"

module sorted_multiset_table_core #(
    parameter int CAPACITY    = smt_pkg::CAPACITY_DEF,
    parameter int VALUE_WIDTH = smt_pkg::VALUE_WIDTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [smt_pkg::S_TDATA_W-1:0] s_tdata,  // [31:0] value
    input  logic [smt_pkg::S_TUSER_W-1:0] s_tuser,  // [1:0] cmd
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [smt_pkg::M_TDATA_W-1:0] m_tdata,  // [4:0] entry_count, [9:5] even_entries,
                                                     // [41:10] total, [47:42] zero
    output logic [smt_pkg::M_TUSER_W-1:0] m_tuser   // [1:0] status, [2] found
);
    import smt_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);

    state_e_t               state_reg;
    state_e_t               state_next;
    cmd_e_t                 cmd_reg;
    logic [VALUE_WIDTH-1:0] val_reg;
    logic [CW-1:0]          count_reg;
    logic [CW-1:0]          count_next;
    logic [CW-1:0]          even_reg;
    logic [CW-1:0]          even_next;
    logic [VALUE_WIDTH-1:0] sum_reg;
    logic [VALUE_WIDTH-1:0] sum_next;
    logic                   m_tvalid_reg;
    status_e_t              status_reg;
    status_e_t              status_next;
    logic                   found_reg;
    logic                   found_next;
    logic [CW-1:0]          count_out_reg;
    logic [CW-1:0]          even_out_reg;
    logic [VALUE_WIDTH-1:0] sum_out_reg;

    logic [VALUE_WIDTH+IN_VALUE_W-1:0]  val_ext;
    logic [VALUE_WIDTH-1:0]             val_in;
    logic [CW+COUNT_FIELD-1:0]          count_ext;
    logic [CW+COUNT_FIELD-1:0]          even_ext;
    logic [VALUE_WIDTH+TOTAL_FIELD-1:0] sum_ext;

    logic      s_accept;
    logic      out_free;
    logic      commit;
    logic      row_found;
    logic      full;
    cell_ctl_t cell_ctl;

    assign val_ext  = {{VALUE_WIDTH{s_tdata[IN_VALUE_W-1]}}, s_tdata[IN_VALUE_W-1:0]};
    assign val_in   = val_ext[VALUE_WIDTH-1:0];
    assign s_accept = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign full     = count_reg >= CW'(CAPACITY);

    smt_row #(
        .CAPACITY    (CAPACITY),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_row (
        .aclk    (aclk),
        .ctl     (cell_ctl),
        .count   (count_reg),
        .cmp_key (val_in),
        .ins_key (val_reg),
        .found   (row_found)
    );

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_tready        = 1'b0;
        commit          = 1'b0;
        cell_ctl.cmp_en = 1'b0;
        cell_ctl.op     = OP_HOLD;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready        = 1'b1;
                cell_ctl.cmp_en = s_tvalid;
            end
            ST_UPDATE: begin
                commit = out_free;
                if (out_free && cmd_reg == CMD_INSERT && !full) begin
                    cell_ctl.op = OP_INSERT;
                end else if (out_free && cmd_reg == CMD_REMOVE && row_found) begin
                    cell_ctl.op = OP_REMOVE;
                end
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

    always_comb begin
        count_next  = count_reg;
        even_next   = even_reg;
        sum_next    = sum_reg;
        status_next = STATUS_DONE;
        found_next  = row_found;
        unique case (cmd_reg)
            CMD_INSERT: begin
                if (full) begin
                    status_next = STATUS_FULL;
                end else begin
                    count_next = count_reg + CW'(1);
                    even_next  = even_reg + CW'(!val_reg[0]);
                    sum_next   = sum_reg + val_reg;
                end
            end
            CMD_REMOVE: begin
                if (!row_found) begin
                    status_next = STATUS_NOT_FOUND;
                end else begin
                    count_next = count_reg - CW'(1);
                    even_next  = even_reg - CW'(!val_reg[0]);
                    sum_next   = sum_reg - val_reg;
                end
            end
            CMD_LOOKUP: begin
                if (!row_found) begin
                    status_next = STATUS_NOT_FOUND;
                end
            end
            CMD_CLEAR: begin
                count_next = '0;
                even_next  = '0;
                sum_next   = '0;
                found_next = 1'b0;
            end
            default: begin
                status_next = STATUS_DONE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            even_reg     <= '0;
            sum_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (commit) begin
                count_reg    <= count_next;
                even_reg     <= even_next;
                sum_reg      <= sum_next;
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            cmd_reg <= cmd_e_t'(s_tuser[CMD_WIDTH-1:0]);
            val_reg <= val_in;
        end
        if (commit) begin
            status_reg    <= status_next;
            found_reg     <= found_next;
            count_out_reg <= count_next;
            even_out_reg  <= even_next;
            sum_out_reg   <= sum_next;
        end
    end

    assign count_ext = {{COUNT_FIELD{1'b0}}, count_out_reg};
    assign even_ext  = {{COUNT_FIELD{1'b0}}, even_out_reg};
    assign sum_ext   = {{TOTAL_FIELD{1'b0}}, sum_out_reg};

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = {found_reg, status_reg};
    assign m_tdata  = {{(M_TDATA_W - 2*COUNT_FIELD - TOTAL_FIELD){1'b0}},
                       sum_ext[TOTAL_FIELD-1:0],
                       even_ext[COUNT_FIELD-1:0],
                       count_ext[COUNT_FIELD-1:0]};

    `SMT_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= CW'(CAPACITY),
        "entry count above capacity")
    `SMT_ASSERT_NOW(a_even_bound, 1'b1, even_reg <= count_reg,
        "even count above entry count")
    `SMT_ASSERT_NEXT(a_accept_update, s_accept, state_reg == ST_UPDATE,
        "accepted word did not reach update")
    `SMT_ASSERT_NEXT(a_commit_result, commit, m_tvalid_reg,
        "committed command left no result")
    `SMT_ASSERT_NOW(a_shift_commit, cell_ctl.op != OP_HOLD, commit,
        "row shifted outside a commit")

endmodule
